FILE: hw/rtl/csmg_pkg.sv
// Shared widths, register map, status type and rounding helper for the channel scale block.
package csmg_pkg;

  localparam int DATA_W       = 16;   // Q8.8 element width
  localparam int PROD_W       = 32;   // Q16.16 product width
  localparam int SUM_W        = 48;   // scale gradient accumulator width
  localparam int SG_W         = 32;   // presented scale gradient width
  localparam int PLANE_SIZE_W = 13;   // plane_size register width
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;

  localparam int MAX_PLANE_DEF = 4096;

  // register index, taken from paddr[2]
  localparam logic REG_MODE       = 1'b0;
  localparam logic REG_PLANE_SIZE = 1'b1;

  localparam logic                    MODE_RST       = 1'b0;
  localparam logic [PLANE_SIZE_W-1:0] PLANE_SIZE_RST = PLANE_SIZE_W'(64);

  typedef struct packed {
    logic                   last;
    logic                   sg_valid;
    logic signed [SG_W-1:0] scale_gradient;
  } plane_stat_t;

  // Q16.16 -> Q8.8, round half up, saturate
  function automatic logic signed [DATA_W-1:0] round_sat16(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W:0]   biased;
    logic signed [PROD_W-8:0] shifted;
    biased  = (PROD_W+1)'(prod) + (PROD_W+1)'(128);
    shifted = (PROD_W-7)'(biased >>> 8);
    if (shifted > (PROD_W-7)'(32767)) begin
      return 16'sh7FFF;
    end else if (shifted < -(PROD_W-7)'(32768)) begin
      return 16'sh8000;
    end else begin
      return shifted[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/csmg_plane_acc.sv
// Plane position counter and scale gradient accumulator.
module csmg_plane_acc #(
  parameter int MAX_PLANE = csmg_pkg::MAX_PLANE_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     upd,
  input  logic                                     backward,
  input  logic        [csmg_pkg::PLANE_SIZE_W-1:0] plane_size,
  input  logic signed [csmg_pkg::PROD_W-1:0]       gf_prod,
  output csmg_pkg::plane_stat_t                    stat
);
  import csmg_pkg::*;

  localparam int PW  = (MAX_PLANE > 1) ? $clog2(MAX_PLANE) : 1;
  localparam int MW  = $clog2(MAX_PLANE + 1);
  localparam int CW  = (MW > PLANE_SIZE_W) ? MW : PLANE_SIZE_W;

  localparam logic [CW-1:0] MAX_C = CW'(MAX_PLANE);
  localparam logic signed [SUM_W-1:0] SG_HI = SUM_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SG_LO = SUM_W'(-64'sh0000_0000_8000_0000);

  logic        [PW-1:0]    pos_r, pos_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SUM_W-1:0] sum_add;
  logic        [CW-1:0]    size_c, eff;
  logic                    last;

  always_comb begin
    size_c = CW'(plane_size);
    if (size_c == '0) begin
      eff = CW'(1);
    end else if (size_c > MAX_C) begin
      eff = MAX_C;
    end else begin
      eff = size_c;
    end
    last = CW'(pos_r) >= (eff - CW'(1));

    sum_add = backward ? (sum_r + SUM_W'(gf_prod)) : sum_r;
    sum_nxt = last ? '0 : sum_add;
    pos_nxt = last ? '0 : pos_r + PW'(1);

    stat.last     = last;
    stat.sg_valid = backward && last;
    if (!(backward && last)) begin
      stat.scale_gradient = '0;
    end else if (sum_add > SG_HI) begin
      stat.scale_gradient = 32'sh7FFF_FFFF;
    end else if (sum_add < SG_LO) begin
      stat.scale_gradient = 32'sh8000_0000;
    end else begin
      stat.scale_gradient = sum_add[SG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else if (upd) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

FILE: hw/rtl/channel_scale_multiply_grad.sv
// Top level: channel-wise scale layer, forward product and backward gradients.
//
// Usage:
//  - Input channel (in_*): one tensor element per transfer with its channel
//    scale and, in backward mode, the output gradient. Q8.8 values.
//  - Output channel (out_*): exactly one result per input transfer, in order.
//    out_scale_gradient carries the saturated plane sum on the last element
//    of a plane in backward mode, zero otherwise.
//  - Config (APB): reg 0 at 0x0 is mode, reg 1 at 0x4 is plane_size.
//    Write only while the block is empty.
//  - Path: an accepted element is held in the input register, then in the
//    result register, which drives out_valid until the result transfers.
//  - Throughput: one transfer per cycle unless stalled; both 16x16 multiplies,
//    the rounding and the 48-bit accumulate sit between the two registers.
//  - Stall: out_stall holds the result register; the input register still
//    fills when empty, so in_stall rises only once both are full.
//  - Reset: pipeline emptied, plane position and sum cleared, mode forward,
//    plane_size 64.
module channel_scale_multiply_grad #(
  parameter int MAX_PLANE = csmg_pkg::MAX_PLANE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [csmg_pkg::DATA_W-1:0]   in_feature_value,
  input  logic signed [csmg_pkg::DATA_W-1:0]   in_channel_scale,
  input  logic signed [csmg_pkg::DATA_W-1:0]   in_output_gradient,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [csmg_pkg::DATA_W-1:0]   out_result_value,
  output logic signed [csmg_pkg::SG_W-1:0]     out_scale_gradient,
  output logic                                 out_scale_gradient_valid,
  output logic                                 out_plane_last,
  // APB config port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [csmg_pkg::APB_AW-1:0]   paddr,
  input  logic        [csmg_pkg::APB_DW-1:0]   pwdata,
  output logic        [csmg_pkg::APB_DW-1:0]   prdata,
  output logic                                 pready
);
  import csmg_pkg::*;

  // ---------------- config registers ----------------
  logic                    mode_r;
  logic [PLANE_SIZE_W-1:0] plane_size_r;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_RST;
      plane_size_r <= PLANE_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MODE:       mode_r       <= pwdata[0];
        REG_PLANE_SIZE: plane_size_r <= pwdata[PLANE_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE:       prdata = APB_DW'(mode_r);
      REG_PLANE_SIZE: prdata = APB_DW'(plane_size_r);
      default:        prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // Each stage loads when it is empty or its content moves on.
  logic s0_vld_r, out_vld_r;
  logic out_load, s0_load;

  assign out_load = !out_vld_r || !out_stall;
  assign s0_load  = !s0_vld_r || out_load;
  assign in_stall = !s0_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s0_load)  s0_vld_r  <= in_valid;
      if (out_load) out_vld_r <= s0_vld_r;
    end
  end

  // ---------------- stage 0: input register ----------------
  logic signed [DATA_W-1:0] feat_r, scale_r, grad_r;

  always_ff @(posedge clk) begin
    if (s0_load && in_valid) begin
      feat_r  <= in_feature_value;
      scale_r <= in_channel_scale;
      grad_r  <= in_output_gradient;
    end
  end

  // ---------------- products ----------------
  // Result product uses gradient in backward mode, feature in forward mode.
  logic signed [DATA_W-1:0] mul_a;
  logic signed [PROD_W-1:0] res_prod, gf_prod;

  assign mul_a    = mode_r ? grad_r : feat_r;
  assign res_prod = mul_a * scale_r;
  assign gf_prod  = grad_r * feat_r;

  // ---------------- round, accumulate, result register ----------------
  plane_stat_t stat;
  logic        acc_upd;

  assign acc_upd = out_load && s0_vld_r;

  csmg_plane_acc #(
    .MAX_PLANE (MAX_PLANE)
  ) u_plane_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (acc_upd),
    .backward   (mode_r),
    .plane_size (plane_size_r),
    .gf_prod    (gf_prod),
    .stat       (stat)
  );

  logic signed [DATA_W-1:0] res_r;
  plane_stat_t              stat_r;

  always_ff @(posedge clk) begin
    if (acc_upd) begin
      res_r  <= round_sat16(res_prod);
      stat_r <= stat;
    end
  end

  assign out_valid                = out_vld_r;
  assign out_result_value         = res_r;
  assign out_scale_gradient       = stat_r.scale_gradient;
  assign out_scale_gradient_valid = stat_r.sg_valid;
  assign out_plane_last           = stat_r.last;

`ifndef SYNTHESIS
  // A scale gradient is only ever presented on a plane end.
  a_sg_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (!stat_r.sg_valid || stat_r.last))
    else $error("scale gradient valid without plane end");

  // Scale gradient reads zero whenever it is not valid.
  a_sg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !stat_r.sg_valid) |-> (stat_r.scale_gradient == '0))
    else $error("scale gradient nonzero while not valid");

  // Forward mode never produces a scale gradient.
  a_fwd_no_sg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !mode_r) |-> !stat_r.sg_valid)
    else $error("scale gradient in forward mode");

  // Input backs up only when both stages are occupied and the output is held.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s0_vld_r && out_vld_r && out_stall))
    else $error("input stalled with a free pipeline slot");
`endif

endmodule

FILE: tb/csmg_checker.sv
// Checker for the channel scale block: predicts every result and compares it on transfer.
`timescale 1ns / 100ps
module csmg_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [csmg_pkg::DATA_W-1:0] in_feature_value,
  input  logic signed [csmg_pkg::DATA_W-1:0] in_channel_scale,
  input  logic signed [csmg_pkg::DATA_W-1:0] in_output_gradient,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [csmg_pkg::DATA_W-1:0] out_result_value,
  input  logic signed [csmg_pkg::SG_W-1:0]   out_scale_gradient,
  input  logic                               out_scale_gradient_valid,
  input  logic                               out_plane_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [csmg_pkg::APB_AW-1:0]        paddr,
  input  logic [csmg_pkg::APB_DW-1:0]        pwdata,
  output int                                 fails,
  output int                                 pending,
  output int                                 n_results,
  output int                                 n_grad_planes
);
  import csmg_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    plane_stat_t              stat;
  } elem_result_t;

  logic                    bwd_mode;
  logic [PLANE_SIZE_W-1:0] plane_size_reg;
  longint                  grad_acc;
  int                      plane_pos;
  elem_result_t            expected_q[$];
  int                      err_count;
  int                      result_count;
  int                      grad_count;

  // Q16.16 -> Q8.8: add half an LSB, floor, clamp
  function automatic logic signed [DATA_W-1:0] q88_round(longint prod);
    longint r;
    r = (prod + 128) >>> 8;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return DATA_W'(r);
  endfunction

  function automatic elem_result_t scale_layer_step(logic signed [DATA_W-1:0] feat,
                                                    logic signed [DATA_W-1:0] scale,
                                                    logic signed [DATA_W-1:0] grad);
    elem_result_t r;
    int           span;
    longint       sg;
    span = int'(plane_size_reg);
    if (span == 0) span = 1;
    if (span > MAX_PLANE_DEF) span = MAX_PLANE_DEF;
    r.stat.last = (plane_pos >= span - 1);
    if (bwd_mode) begin
      r.value  = q88_round(longint'(grad) * longint'(scale));
      grad_acc = grad_acc + longint'(grad) * longint'(feat);
    end else begin
      r.value = q88_round(longint'(feat) * longint'(scale));
    end
    r.stat.sg_valid       = bwd_mode && r.stat.last;
    r.stat.scale_gradient = '0;
    if (r.stat.sg_valid) begin
      sg = grad_acc;
      if (sg > 64'sd2147483647) sg = 64'sd2147483647;
      if (sg < -64'sd2147483648) sg = -64'sd2147483648;
      r.stat.scale_gradient = SG_W'(sg);
    end
    if (r.stat.last) begin
      grad_acc  = 0;
      plane_pos = 0;
    end else begin
      plane_pos++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    elem_result_t exp_r;
    if (!rst_n) begin
      bwd_mode       = MODE_RST;
      plane_size_reg = PLANE_SIZE_RST;
      grad_acc       = 0;
      plane_pos      = 0;
      expected_q.delete();
    end else begin
      // pop before push: an input cannot reach the output in the same cycle
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $error("result transfer with no expected result pending");
          err_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_result_value !== exp_r.value) begin
            $error("result_value: expected %0d, actual %0d", exp_r.value, out_result_value);
            err_count++;
          end
          if (out_scale_gradient !== exp_r.stat.scale_gradient) begin
            $error("scale_gradient: expected %0d, actual %0d",
                   exp_r.stat.scale_gradient, out_scale_gradient);
            err_count++;
          end
          if (out_scale_gradient_valid !== exp_r.stat.sg_valid) begin
            $error("scale_gradient_valid: expected %0b, actual %0b",
                   exp_r.stat.sg_valid, out_scale_gradient_valid);
            err_count++;
          end
          if (out_plane_last !== exp_r.stat.last) begin
            $error("plane_last: expected %0b, actual %0b", exp_r.stat.last, out_plane_last);
            err_count++;
          end
          if (exp_r.stat.sg_valid) grad_count++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(scale_layer_step(in_feature_value, in_channel_scale,
                                              in_output_gradient));
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MODE) begin
          bwd_mode = pwdata[0];
        end else begin
          plane_size_reg = pwdata[PLANE_SIZE_W-1:0];
        end
      end
    end
    fails         <= err_count;
    pending       <= expected_q.size();
    n_results     <= result_count;
    n_grad_planes <= grad_count;
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top: reset, register setup, element stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;
  import csmg_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;   // quiet cycles before giving up
  localparam int DRAIN_CYCLES   = 8;      // pipeline is 2 deep, allow margin
  localparam int PHASE_ITEMS    = 560;    // minimum random elements per idling phase

  logic                     clk                = 1'b0;
  logic                     rst_n              = 1'b0;
  logic                     in_valid           = 1'b0;
  logic signed [DATA_W-1:0] in_feature_value   = '0;
  logic signed [DATA_W-1:0] in_channel_scale   = '0;
  logic signed [DATA_W-1:0] in_output_gradient = '0;
  logic                     out_stall          = 1'b0;
  logic                     psel               = 1'b0;
  logic                     penable            = 1'b0;
  logic                     pwrite             = 1'b0;
  logic [APB_AW-1:0]        paddr              = '0;
  logic [APB_DW-1:0]        pwdata             = '0;

  logic                     in_stall;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_result_value;
  logic signed [SG_W-1:0]   out_scale_gradient;
  logic                     out_scale_gradient_valid;
  logic                     out_plane_last;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  int fail_count;
  int pending_results;
  int n_results;
  int n_grad_planes;

  // idle percentages for the sender (gaps between transfers) and receiver (stalls)
  int gap_pct   = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  channel_scale_multiply_grad u_top (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_feature_value         (in_feature_value),
    .in_channel_scale         (in_channel_scale),
    .in_output_gradient       (in_output_gradient),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_result_value         (out_result_value),
    .out_scale_gradient       (out_scale_gradient),
    .out_scale_gradient_valid (out_scale_gradient_valid),
    .out_plane_last           (out_plane_last),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready)
  );

  csmg_checker u_checker (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_feature_value         (in_feature_value),
    .in_channel_scale         (in_channel_scale),
    .in_output_gradient       (in_output_gradient),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_result_value         (out_result_value),
    .out_scale_gradient       (out_scale_gradient),
    .out_scale_gradient_valid (out_scale_gradient_valid),
    .out_plane_last           (out_plane_last),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .pready                   (pready),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .fails                    (fail_count),
    .pending                  (pending_results),
    .n_results                (n_results),
    .n_grad_planes            (n_grad_planes)
  );

  // Receiver backpressure: a fresh random draw every cycle, stalling with probability stall_pct.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any transfer or register access counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Random Q8.8 value: extremes, full-range noise, or small magnitudes so
  // that plane sums stay in range often enough to exercise the unsaturated path.
  function automatic logic signed [DATA_W-1:0] rand_q88();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = 16'sh0000;
          3: v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      1, 2, 3: v = DATA_W'($urandom);
      default: v = DATA_W'(int'($urandom_range(0, 1023)) - 512);
    endcase
    return v;
  endfunction

  // Mostly small planes; now and then large or out-of-range sizes, which
  // leave the plane open across later settings.
  function automatic logic [PLANE_SIZE_W-1:0] rand_plane_size();
    logic [PLANE_SIZE_W-1:0] s;
    case ($urandom_range(0, 19))
      0: s = '0;
      1: s = PLANE_SIZE_W'(MAX_PLANE_DEF);
      2: s = '1;
      3: s = PLANE_SIZE_W'($urandom_range(MAX_PLANE_DEF + 1, 8191));
      4, 5: s = PLANE_SIZE_W'($urandom_range(17, 300));
      default: s = PLANE_SIZE_W'($urandom_range(1, 16));
    endcase
    return s;
  endfunction

  // One element transfer. Called on a clock edge; returns on the edge that
  // accepted it, so every edge sees at most one assignment to in_valid.
  task automatic push_element(input logic signed [DATA_W-1:0] feat,
                              input logic signed [DATA_W-1:0] scale,
                              input logic signed [DATA_W-1:0] grad);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_feature_value   <= feat;
    in_channel_scale   <= scale;
    in_output_gradient <= grad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait for every expected result to come back.
  // The extra edge lets the checker's pending count catch up.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then the bus is released before the task returns.
  task automatic apb_write(input logic idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_layer(input logic bwd, input logic [PLANE_SIZE_W-1:0] size);
    wait_idle();
    apb_write(REG_MODE, APB_DW'(bwd));
    apb_write(REG_PLANE_SIZE, APB_DW'(size));
  endtask

  initial begin
    int sent;
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, run under the first idling mix ----
    gap_pct   = 32;
    stall_pct = 49;

    // forward: saturation both ways and the round-half-up tie
    set_layer(1'b0, 13'd4);
    push_element(-16'sd32768, -16'sd32768, 16'sd0);
    push_element(16'sd32767, 16'sd32767, -16'sd1);
    push_element(-16'sd32768, 16'sd32767, 16'sd32767);
    push_element(16'sd1, 16'sd128, 16'sd0);      // exactly half an LSB, rounds up
    push_element(-16'sd1, 16'sd128, 16'sd0);     // minus half, rounds to zero

    // backward: large products of both signs; the first plane sum overflows 32 bits
    set_layer(1'b1, 13'd3);
    repeat (3) push_element(-16'sd32768, 16'sd32767, -16'sd32768);
    repeat (3) push_element(16'sd32767, -16'sd32768, -16'sd32768);

    // mode flipped mid-plane: the forward element adds nothing to the sum
    set_layer(1'b1, 13'd4);
    push_element(16'sd256, 16'sd256, 16'sd256);
    push_element(16'sd512, -16'sd256, 16'sd256);
    wait_idle();
    apb_write(REG_MODE, APB_DW'(1'b0));
    push_element(16'sd100, 16'sd100, 16'sd100);
    wait_idle();
    apb_write(REG_MODE, APB_DW'(1'b1));
    push_element(-16'sd256, 16'sd256, 16'sd512);

    // a forward element opening a backward plane adds nothing to its sum
    set_layer(1'b1, 13'd3);
    push_element(16'sd1000, 16'sd256, 16'sd2000);
    push_element(-16'sd700, 16'sd256, 16'sd300);
    wait_idle();
    apb_write(REG_MODE, APB_DW'(1'b0));
    push_element(16'sd5, 16'sd5, 16'sd5);
    wait_idle();
    apb_write(REG_MODE, APB_DW'(1'b1));
    repeat (3) push_element(16'sd256, 16'sd128, 16'sd256);

    // plane shrunk below the current position: next element closes the plane
    set_layer(1'b1, 13'd8);
    repeat (4) push_element(16'sd300, -16'sd300, 16'sd300);
    wait_idle();
    apb_write(REG_PLANE_SIZE, APB_DW'(13'd3));
    push_element(16'sd300, -16'sd300, 16'sd300);

    // zero size acts as one: every element ends a plane
    set_layer(1'b1, 13'd0);
    push_element(16'sd1234, -16'sd4321, 16'sd77);
    push_element(-16'sd1, 16'sd1, 16'sd32767);

    // ---- random part: three idling mixes ----
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          gap_pct   = 32;
          stall_pct = 49;
        end
        1: begin
          gap_pct   = 49;
          stall_pct = 32;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        set_layer(1'($urandom_range(0, 1)), rand_plane_size());
        n = $urandom_range(10, 60);
        repeat (n) push_element(rand_q88(), rand_q88(), rand_q88());
        sent += n;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d element results, %0d of them carrying a scale gradient,",
             n_results, n_grad_planes);
    $display("in forward and backward modes, plane sizes 0 to 8191, three idling mixes.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
